@@ src/tspwm_pkg.sv @@
package tspwm_pkg;

    // Configuration register map
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_MOD_DEPTH    = 3'd1,
        REG_DC_OFFSET    = 3'd2,
        REG_TIMER_PERIOD = 3'd3,
        REG_LEAD_A       = 3'd4,
        REG_LEAD_B       = 3'd5,
        REG_LEAD_C       = 3'd6
    } cfg_reg_t;

    localparam logic [31:0] RST_PHASE_STEP   = 32'd103079215;
    localparam logic [15:0] RST_MOD_DEPTH    = 16'd32768;
    localparam logic [15:0] RST_DC_OFFSET    = 16'd0;
    localparam logic [15:0] RST_TIMER_PERIOD = 16'd0;
    localparam logic [15:0] RST_LEAD_A       = 16'd0;
    localparam logic [15:0] RST_LEAD_B       = 16'd21845;
    localparam logic [15:0] RST_LEAD_C       = 16'd43691;

    // Q30 constants for the sine table build
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

@@ src/three_phase_sine_pwm_compare.sv @@
// Three-phase sine PWM compare generator. Each accepted item with period_tick
// set produces one result: three compare values (0..timer_period) and a flag
// that is set when any of them was saturated; an item with period_tick clear
// is taken and produces nothing. The phase accumulator advances by phase_step
// after each result is formed. Each phase goes through a shared bit-serial
// shift-add multiplier: a quarter-wave ROM lookup, sine times depth, forming
// and clamping the inverted duty, and the scaling by timer_period when no
// clamp or zero period cuts it short. in_stall stays high from accept until
// the result is loaded into the output register, so no new item is taken while
// one is in work. The result sits in an output register, so the next tick is
// taken and worked on while a result still waits to be taken.
// Configuration writes are always ready and belong in idle periods only.
module three_phase_sine_pwm_compare #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int ACCUM_BITS     = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             period_tick,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [15:0]                      compare_a,
    output logic [15:0]                      compare_b,
    output logic [15:0]                      compare_c,
    output logic                             clamped,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tspwm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    import tspwm_pkg::*;

    localparam int QBITS  = SINE_ADDR_BITS - 2;
    localparam int Q      = 1 << QBITS;
    localparam int ADDR_W = QBITS + 1;

    localparam logic [4:0] MUL1_LAST = 5'd15;
    localparam logic [4:0] MUL2_LAST = 5'd31;

    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_B = 2'd1;
    localparam logic [1:0] PHASE_C = 2'd2;

    typedef logic [14:0] qtab_t [0:Q];

    // Quarter-wave Q15 sine, entries 0..Q inclusive
    function automatic qtab_t build_qtab();
        qtab_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        for (int r = 0; r <= Q; r++)
        begin
            x  = (64'(r) * HALF_PI_Q30 + (64'd1 << (QBITS - 1))) >> QBITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            v  = (s + 64'd16384) >> 15;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            tab[r] = v[14:0];
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOKUP = 6'b000010,
        S_MUL1   = 6'b000100,
        S_INV    = 6'b001000,
        S_MUL2   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // Configuration registers
    logic [31:0]        phase_step_reg;
    logic [15:0]        mod_depth_reg;
    logic [15:0]        dc_offset_reg;
    logic [15:0]        timer_period_reg;
    logic [15:0]        lead_a_reg;
    logic [15:0]        lead_b_reg;
    logic [15:0]        lead_c_reg;

    // Control
    state_t             state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [ACCUM_BITS-1:0] accum_reg, accum_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath
    logic [14:0]        rom_reg, rom_next;
    logic               neg_reg, neg_next;
    logic [31:0]        mr_reg, mr_next;
    logic [47:0]        pr_reg, pr_next;
    logic               clamp_acc_reg, clamp_acc_next;
    logic [15:0]        cmp_a_reg, cmp_a_next;
    logic [15:0]        cmp_b_reg, cmp_b_next;
    logic [15:0]        cmp_c_reg, cmp_c_next;
    logic [15:0]        compare_a_reg, compare_a_next;
    logic [15:0]        compare_b_reg, compare_b_next;
    logic [15:0]        compare_c_reg, compare_c_next;
    logic               clamped_reg, clamped_next;

    // Combinational helpers
    logic [15:0]        lead_sel;
    logic [15:0]        pos_hi;
    logic [SINE_ADDR_BITS-1:0] rom_k;
    logic [1:0]         quad;
    logic [ADDR_W-1:0]  rom_addr;
    logic [15:0]        mcand;
    logic [16:0]        step_sum;
    logic [34:0]        prod_term;
    logic [34:0]        off_term;
    logic [34:0]        inv;
    logic               inv_neg;
    logic               inv_over;
    logic               phase_done;
    logic [15:0]        phase_result;
    logic               phase_clamp;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign compare_a = compare_a_reg;
    assign compare_b = compare_b_reg;
    assign compare_c = compare_c_reg;
    assign clamped   = clamped_reg;

    always_comb
    begin
        unique case (phase_reg)
            PHASE_A: lead_sel = lead_a_reg;
            PHASE_B: lead_sel = lead_b_reg;
            default: lead_sel = lead_c_reg;
        endcase
    end

    // Lead has no bits below the top 16 of the accumulator, so no carry comes from below
    assign pos_hi   = accum_reg[ACCUM_BITS-1 -: 16] + lead_sel;
    assign rom_k    = pos_hi[15 -: SINE_ADDR_BITS];
    assign quad     = rom_k[SINE_ADDR_BITS-1 -: 2];
    assign rom_addr = quad[0] ? (ADDR_W'(Q) - {1'b0, rom_k[QBITS-1:0]})
                              : {1'b0, rom_k[QBITS-1:0]};

    // Shared shift-add step: one multiplier bit per cycle
    assign mcand    = (state_reg == S_MUL1) ? {1'b0, rom_reg} : timer_period_reg;
    assign step_sum = {1'b0, pr_reg[47:32]} + (mr_reg[0] ? {1'b0, mcand} : 17'd0);

    // inv = 2^30 - sin*depth + offset*2^16, Q31
    assign prod_term = {3'b000, pr_reg[47:16]};
    assign off_term  = {{3{dc_offset_reg[15]}}, dc_offset_reg, 16'd0};
    assign inv       = (35'd1 << 30) + off_term + (neg_reg ? prod_term : (~prod_term + 35'd1));
    assign inv_neg   = inv[34];
    assign inv_over  = !inv[34] && (inv[33:0] > (34'd1 << 31));

    always_comb
    begin
        phase_done   = 1'b0;
        phase_result = 16'd0;
        phase_clamp  = 1'b0;
        if (state_reg == S_INV)
        begin
            if (timer_period_reg == 16'd0)
            begin
                phase_done = 1'b1;
            end
            else if (inv_neg)
            begin
                phase_done  = 1'b1;
                phase_clamp = 1'b1;
            end
            else if (inv_over)
            begin
                phase_done   = 1'b1;
                phase_result = timer_period_reg;
                phase_clamp  = 1'b1;
            end
        end
        else if ((state_reg == S_MUL2) && (cnt_reg == MUL2_LAST))
        begin
            phase_done   = 1'b1;
            phase_result = step_sum[15:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        accum_next     = accum_reg;
        out_valid_next = out_valid_reg && out_stall;
        rom_next       = rom_reg;
        neg_next       = neg_reg;
        mr_next        = mr_reg;
        pr_next        = pr_reg;
        clamp_acc_next = clamp_acc_reg;
        cmp_a_next     = cmp_a_reg;
        cmp_b_next     = cmp_b_reg;
        cmp_c_next     = cmp_c_reg;
        compare_a_next = compare_a_reg;
        compare_b_next = compare_b_reg;
        compare_c_next = compare_c_reg;
        clamped_next   = clamped_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && period_tick)
                begin
                    phase_next     = PHASE_A;
                    clamp_acc_next = 1'b0;
                    state_next     = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                rom_next   = QTAB[rom_addr];
                neg_next   = quad[1];
                mr_next    = {16'd0, mod_depth_reg};
                pr_next    = 48'd0;
                cnt_next   = 5'd0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                pr_next  = {step_sum, pr_reg[31:1]};
                mr_next  = mr_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == MUL1_LAST)
                begin
                    state_next = S_INV;
                end
            end
            S_INV:
            begin
                mr_next    = inv[31:0];
                pr_next    = 48'd0;
                cnt_next   = 5'd0;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                pr_next  = {step_sum, pr_reg[31:1]};
                mr_next  = mr_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    compare_a_next = cmp_a_reg;
                    compare_b_next = cmp_b_reg;
                    compare_c_next = cmp_c_reg;
                    clamped_next   = clamp_acc_reg;
                    accum_next     = accum_reg + ACCUM_BITS'(phase_step_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (phase_done)
        begin
            clamp_acc_next = clamp_acc_reg | phase_clamp;
            unique case (phase_reg)
                PHASE_A: cmp_a_next = phase_result;
                PHASE_B: cmp_b_next = phase_result;
                default: cmp_c_next = phase_result;
            endcase
            if (phase_reg == PHASE_C)
            begin
                state_next = S_DONE;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                state_next = S_LOOKUP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PHASE_A;
            cnt_reg       <= 5'd0;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            accum_reg     <= accum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rom_reg       <= rom_next;
        neg_reg       <= neg_next;
        mr_reg        <= mr_next;
        pr_reg        <= pr_next;
        clamp_acc_reg <= clamp_acc_next;
        cmp_a_reg     <= cmp_a_next;
        cmp_b_reg     <= cmp_b_next;
        cmp_c_reg     <= cmp_c_next;
        compare_a_reg <= compare_a_next;
        compare_b_reg <= compare_b_next;
        compare_c_reg <= compare_c_next;
        clamped_reg   <= clamped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= RST_PHASE_STEP;
            mod_depth_reg    <= RST_MOD_DEPTH;
            dc_offset_reg    <= RST_DC_OFFSET;
            timer_period_reg <= RST_TIMER_PERIOD;
            lead_a_reg       <= RST_LEAD_A;
            lead_b_reg       <= RST_LEAD_B;
            lead_c_reg       <= RST_LEAD_C;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                REG_MOD_DEPTH:    mod_depth_reg    <= cfg_data[15:0];
                REG_DC_OFFSET:    dc_offset_reg    <= cfg_data[15:0];
                REG_TIMER_PERIOD: timer_period_reg <= cfg_data[15:0];
                REG_LEAD_A:       lead_a_reg       <= cfg_data[15:0];
                REG_LEAD_B:       lead_b_reg       <= cfg_data[15:0];
                REG_LEAD_C:       lead_c_reg       <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

endmodule

@@ src/tspwm_checker.sv @@
module tspwm_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             period_tick,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [15:0]                      compare_a,
    input  logic [15:0]                      compare_b,
    input  logic [15:0]                      compare_c,
    input  logic                             clamped,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tspwm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    import tspwm_pkg::*;

    // Tracks the period as written through the config port
    logic [15:0] period_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_shadow_reg <= RST_TIMER_PERIOD;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == REG_TIMER_PERIOD))
        begin
            period_shadow_reg <= cfg_data[15:0];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(compare_a) && $stable(compare_b)
            && $stable(compare_c) && $stable(clamped))
        else $error("result changed while stalled");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (compare_a <= period_shadow_reg) && (compare_b <= period_shadow_reg)
            && (compare_c <= period_shadow_reg))
        else $error("compare value above timer period");

    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (period_shadow_reg == 16'd0) |-> !clamped)
        else $error("clamp flagged with zero period");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && period_tick |=> in_stall)
        else $error("tick item accepted without going busy");

endmodule

bind three_phase_sine_pwm_compare tspwm_checker u_tspwm_checker (.*);
